>>> sv/mlcam_pkg.sv
package mlcam_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 14;
  localparam int SCROLL_W    = 16;
  localparam int FRONT_W     = 16;
  localparam int YAW_W       = 12;
  localparam int PITCH_W     = 11;
  localparam int FOV_W       = 14;
  localparam int IDX_W       = 10;

  localparam logic [CFG_INDEX_W-1:0] CFG_START_YAW   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_PITCH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_FOV   = 2'd2;

  localparam logic REQ_MOVE   = 1'b0;
  localparam logic REQ_SCROLL = 1'b1;

  localparam int YAW_FULL           = 3600;
  localparam int QUARTER_TURN       = 900;
  localparam int HALF_TURN          = 1800;
  localparam int THREE_QUARTER_TURN = 2700;
  localparam int PITCH_LIMIT        = 890;
  localparam int DY_LIMIT           = 2 * PITCH_LIMIT;
  localparam int FOV_MIN            = 256;
  localparam int FOV_MAX            = 11520;

  localparam logic [YAW_W-1:0]          START_YAW_RESET   = 12'd2700;
  localparam logic signed [PITCH_W-1:0] START_PITCH_RESET = 11'sd0;
  localparam logic [FOV_W-1:0]          START_FOV_RESET   = 14'd11520;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned SINE_DEN [0:4] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  // Taylor series sine in Q30, rounded to frac_bits and capped
  function automatic longint unsigned quarter_sine(input int unsigned a,
                                                   input int unsigned frac_bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    x  = (longint'(a) * PI_Q30) / 64'd1800;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    for (int i = 0; i < 5; i++) begin
      t = ONE_Q30 - ((x2 * t) >> 30) / SINE_DEN[i];
    end
    s = (x * t) >> 30;
    if (frac_bits < 30) begin
      s = (s + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
    end
    if (s > (64'd1 << frac_bits) - 64'd1) begin
      s = (64'd1 << frac_bits) - 64'd1;
    end
    return s;
  endfunction

endpackage

>>> sv/mlcam_cfg_if.sv
interface mlcam_cfg_if
  import mlcam_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/mlcam_req_if.sv
interface mlcam_req_if
  import mlcam_pkg::*;
#(
  parameter int POSITION_BITS = 16
);
  logic                            valid;
  logic                            ready;
  logic                            req_type;
  logic signed [POSITION_BITS-1:0] x_pos;
  logic signed [POSITION_BITS-1:0] y_pos;
  logic signed [SCROLL_W-1:0]      scroll_offset;

  modport source (output valid, req_type, x_pos, y_pos, scroll_offset, input ready);
  modport sink   (input valid, req_type, x_pos, y_pos, scroll_offset, output ready);
endinterface

>>> sv/mlcam_res_if.sv
interface mlcam_res_if
  import mlcam_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [FRONT_W-1:0] front_x;
  logic signed [FRONT_W-1:0] front_y;
  logic signed [FRONT_W-1:0] front_z;
  logic [YAW_W-1:0]          yaw_angle;
  logic signed [PITCH_W-1:0] pitch_angle;
  logic [FOV_W-1:0]          fov_angle;

  modport source (output valid, front_x, front_y, front_z, yaw_angle, pitch_angle,
                  fov_angle, input ready);
  modport sink   (input valid, front_x, front_y, front_z, yaw_angle, pitch_angle,
                  fov_angle, output ready);
endinterface

>>> sv/mouse_look_camera_orientation_unit.sv
// Mouse-look camera orientation.
// req carries pointer events: a move (x_pos, y_pos) or a wheel scroll (scroll_offset).
// Each transfer on req yields exactly one transfer on res: the front vector in
// Q1.FRONT_FRACTION_BITS plus the current yaw, pitch and field of view.
// cfg writes the start yaw, pitch and fov; they are taken by the first item
// after reset. cfg is always ready; write it only while the block is idle.
// Throughput: one item per cycle while res does not hold the output, set by the
// yaw/pitch/fov update in stage four.
// Stages: delta capture, reciprocal multiply for yaw mod 360 degrees,
// remainder, orientation update, sine table read, front vector products.
// Each stage advances when the next one is empty or moving, so req keeps
// taking items into empty stages while a result waits on res.
// Reset (rst, synchronous) empties the pipeline, restores the start registers,
// clears the orientation and marks the first move as pending.
module mouse_look_camera_orientation_unit
  import mlcam_pkg::*;
#(
  parameter int POSITION_BITS       = 16,
  parameter int FRONT_FRACTION_BITS = 15
) (
  input  logic         clk,
  input  logic         rst,
  mlcam_cfg_if.sink    cfg,
  mlcam_req_if.sink    req,
  mlcam_res_if.source  res
);

  localparam int PB = POSITION_BITS;
  localparam int F  = FRONT_FRACTION_BITS;
  localparam int RECIP_SHIFT = PB + 12;
  localparam int RW = PB + 1;
  localparam longint unsigned RECIP =
    ((64'd1 << RECIP_SHIFT) + longint'(YAW_FULL - 1)) / longint'(YAW_FULL);
  localparam logic [RW-1:0] RECIP_K = RW'(RECIP);
  localparam int W = (F + 2 > FRONT_W) ? F + 2 : FRONT_W;

  typedef logic [F-1:0] sine_rom_t [0:QUARTER_TURN];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int a = 0; a <= QUARTER_TURN; a++) begin
      rom[a] = F'(quarter_sine(a, F));
    end
    return rom;
  endfunction

  localparam sine_rom_t YAW_ROM   = build_sine_rom();
  localparam sine_rom_t PITCH_ROM = build_sine_rom();

  // sign and table index of the sine of a yaw angle in 0..3599
  function automatic logic [IDX_W:0] yaw_quad(input logic [YAW_W-1:0] a);
    logic [IDX_W:0] r;
    if (a <= YAW_W'(QUARTER_TURN)) begin
      r = {1'b0, IDX_W'(a)};
    end else if (a <= YAW_W'(HALF_TURN)) begin
      r = {1'b0, IDX_W'(YAW_W'(HALF_TURN) - a)};
    end else if (a <= YAW_W'(THREE_QUARTER_TURN)) begin
      r = {1'b1, IDX_W'(a - YAW_W'(HALF_TURN))};
    end else begin
      r = {1'b1, IDX_W'(YAW_W'(YAW_FULL) - a)};
    end
    return r;
  endfunction

  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  logic v1, v2, v3, v4, v5, v6;

  assign rdy6 = !v6 || res.ready;
  assign rdy5 = !v5 || rdy6;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign req.ready = rdy1;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (rdy1) v1 <= req.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
      if (rdy6) v6 <= v5;
    end
  end

  logic en1, en2, en3, en4, en5, en6;
  assign en1 = req.valid && rdy1;
  assign en2 = v1 && rdy2;
  assign en3 = v2 && rdy3;
  assign en4 = v3 && rdy4;
  assign en5 = v4 && rdy5;
  assign en6 = v5 && rdy6;

  // start registers
  logic [YAW_W-1:0]          start_yaw;
  logic signed [PITCH_W-1:0] start_pitch;
  logic [FOV_W-1:0]          start_fov;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_yaw   <= START_YAW_RESET;
      start_pitch <= START_PITCH_RESET;
      start_fov   <= START_FOV_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_START_YAW:   start_yaw   <= cfg.data[YAW_W-1:0];
        CFG_START_PITCH: start_pitch <= signed'(cfg.data[PITCH_W-1:0]);
        CFG_START_FOV:   start_fov   <= cfg.data[FOV_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: position deltas
  logic                 first_pend;
  logic signed [PB-1:0] last_x, last_y;
  logic signed [PB:0]   dx_next, dy_next;
  logic                 s1_type;
  logic signed [PB:0]   s1_dx, s1_dy;
  logic signed [SCROLL_W-1:0] s1_scroll;

  always_comb begin
    if (first_pend) begin
      dx_next = '0;
      dy_next = '0;
    end else begin
      dx_next = (PB+1)'(req.x_pos) - (PB+1)'(last_x);
      dy_next = (PB+1)'(last_y) - (PB+1)'(req.y_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_pend <= 1'b1;
      last_x     <= '0;
      last_y     <= '0;
    end else if (en1 && req.req_type == REQ_MOVE) begin
      first_pend <= 1'b0;
      last_x     <= req.x_pos;
      last_y     <= req.y_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_type   <= req.req_type;
      s1_dx     <= dx_next;
      s1_dy     <= dy_next;
      s1_scroll <= req.scroll_offset;
    end
  end

  // stage 2: quotient of |dx| by a full turn, clamp dy
  logic                       s1_neg;
  logic [PB-1:0]              s1_mag;
  logic [PB+RW-1:0]           q_prod;
  logic [PB-1:0]              q_next;
  logic signed [YAW_W-1:0]    dyc_next;
  logic                       s2_type, s2_neg;
  logic [PB-1:0]              s2_mag, s2_q;
  logic signed [YAW_W-1:0]    s2_dy;
  logic signed [SCROLL_W-1:0] s2_scroll;

  always_comb begin
    s1_neg = s1_dx[PB];
    s1_mag = s1_neg ? PB'(-s1_dx) : PB'(s1_dx);
    q_prod = (PB+RW)'(s1_mag) * (PB+RW)'(RECIP_K);
    q_next = PB'(q_prod >> RECIP_SHIFT);
    if (longint'(s1_dy) > longint'(DY_LIMIT)) begin
      dyc_next = YAW_W'(DY_LIMIT);
    end else if (longint'(s1_dy) < -longint'(DY_LIMIT)) begin
      dyc_next = -YAW_W'(DY_LIMIT);
    end else begin
      dyc_next = YAW_W'(s1_dy);
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_type   <= s1_type;
      s2_neg    <= s1_neg;
      s2_mag    <= s1_mag;
      s2_q      <= q_next;
      s2_dy     <= dyc_next;
      s2_scroll <= s1_scroll;
    end
  end

  // stage 3: yaw delta modulo a full turn
  logic [PB+11:0]             q_turns;
  logic [YAW_W-1:0]           rem;
  logic [YAW_W-1:0]           dxm_next;
  logic                       s3_type;
  logic [YAW_W-1:0]           s3_dxm;
  logic signed [YAW_W-1:0]    s3_dy;
  logic signed [SCROLL_W-1:0] s3_scroll;

  always_comb begin
    q_turns  = (PB+12)'(s2_q) * (PB+12)'(YAW_FULL);
    rem      = YAW_W'((PB+12)'(s2_mag) - q_turns);
    dxm_next = (s2_neg && rem != '0) ? YAW_W'(YAW_FULL) - rem : rem;
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_type   <= s2_type;
      s3_dxm    <= dxm_next;
      s3_dy     <= s2_dy;
      s3_scroll <= s2_scroll;
    end
  end

  // stage 4: orientation state
  logic                      loaded;
  logic [YAW_W-1:0]          yaw;
  logic signed [PITCH_W-1:0] pitch;
  logic [FOV_W-1:0]          fov;
  logic [YAW_W-1:0]          base_yaw, yaw_next;
  logic signed [PITCH_W-1:0] base_pitch, pitch_next;
  logic [FOV_W-1:0]          base_fov, fov_next;
  logic [YAW_W:0]            yaw_sum;
  logic signed [PITCH_W+1:0] pitch_sum;
  logic signed [FOV_W+3:0]   fov_sum;

  always_comb begin
    if (loaded) begin
      base_yaw   = yaw;
      base_pitch = pitch;
      base_fov   = fov;
    end else begin
      base_yaw = (start_yaw >= YAW_W'(YAW_FULL)) ? start_yaw - YAW_W'(YAW_FULL) : start_yaw;
      if (start_pitch > PITCH_W'(PITCH_LIMIT)) begin
        base_pitch = PITCH_W'(PITCH_LIMIT);
      end else if (start_pitch < -PITCH_W'(PITCH_LIMIT)) begin
        base_pitch = -PITCH_W'(PITCH_LIMIT);
      end else begin
        base_pitch = start_pitch;
      end
      if (start_fov < FOV_W'(FOV_MIN)) begin
        base_fov = FOV_W'(FOV_MIN);
      end else if (start_fov > FOV_W'(FOV_MAX)) begin
        base_fov = FOV_W'(FOV_MAX);
      end else begin
        base_fov = start_fov;
      end
    end

    yaw_sum   = (YAW_W+1)'(base_yaw) + (YAW_W+1)'(s3_dxm);
    pitch_sum = (PITCH_W+2)'(base_pitch) + (PITCH_W+2)'(s3_dy);
    fov_sum   = signed'((FOV_W+4)'(base_fov)) - (FOV_W+4)'(s3_scroll);

    yaw_next   = base_yaw;
    pitch_next = base_pitch;
    fov_next   = base_fov;
    if (s3_type == REQ_MOVE) begin
      yaw_next = (yaw_sum >= (YAW_W+1)'(YAW_FULL)) ? YAW_W'(yaw_sum - (YAW_W+1)'(YAW_FULL))
                                                   : YAW_W'(yaw_sum);
      if (pitch_sum > (PITCH_W+2)'(PITCH_LIMIT)) begin
        pitch_next = PITCH_W'(PITCH_LIMIT);
      end else if (pitch_sum < -(PITCH_W+2)'(PITCH_LIMIT)) begin
        pitch_next = -PITCH_W'(PITCH_LIMIT);
      end else begin
        pitch_next = PITCH_W'(pitch_sum);
      end
    end else begin
      if (fov_sum > (FOV_W+4)'(FOV_MAX)) begin
        fov_next = FOV_W'(FOV_MAX);
      end else if (fov_sum < (FOV_W+4)'(FOV_MIN)) begin
        fov_next = FOV_W'(FOV_MIN);
      end else begin
        fov_next = FOV_W'(fov_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= 1'b0;
      yaw    <= '0;
      pitch  <= '0;
      fov    <= '0;
    end else if (en4) begin
      loaded <= 1'b1;
      yaw    <= yaw_next;
      pitch  <= pitch_next;
      fov    <= fov_next;
    end
  end

  // stage 5: sine table reads
  logic [YAW_W:0]            cy_sum;
  logic [YAW_W-1:0]          cy_angle;
  logic [IDX_W:0]            sy_q, cy_q;
  logic [IDX_W-1:0]          sp_idx, cp_idx;
  logic signed [YAW_W-1:0]   cp_angle;
  logic                      s5_sy_neg, s5_cy_neg, s5_sp_neg;
  logic [F-1:0]              s5_sy, s5_cy, s5_sp, s5_cp;
  logic [YAW_W-1:0]          s5_yaw;
  logic signed [PITCH_W-1:0] s5_pitch;
  logic [FOV_W-1:0]          s5_fov;

  always_comb begin
    cy_sum   = (YAW_W+1)'(yaw) + (YAW_W+1)'(QUARTER_TURN);
    cy_angle = (cy_sum >= (YAW_W+1)'(YAW_FULL)) ? YAW_W'(cy_sum - (YAW_W+1)'(YAW_FULL))
                                                : YAW_W'(cy_sum);
    sy_q     = yaw_quad(yaw);
    cy_q     = yaw_quad(cy_angle);
    sp_idx   = pitch[PITCH_W-1] ? IDX_W'(-pitch) : IDX_W'(pitch);
    cp_angle = YAW_W'(pitch) + YAW_W'(QUARTER_TURN);
    cp_idx   = (cp_angle <= YAW_W'(QUARTER_TURN)) ? IDX_W'(cp_angle)
                                                  : IDX_W'(YAW_W'(HALF_TURN) - cp_angle);
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_sy     <= YAW_ROM[sy_q[IDX_W-1:0]];
      s5_cy     <= YAW_ROM[cy_q[IDX_W-1:0]];
      s5_sp     <= PITCH_ROM[sp_idx];
      s5_cp     <= PITCH_ROM[cp_idx];
      s5_sy_neg <= sy_q[IDX_W];
      s5_cy_neg <= cy_q[IDX_W];
      s5_sp_neg <= pitch[PITCH_W-1];
      s5_yaw    <= yaw;
      s5_pitch  <= pitch;
      s5_fov    <= fov;
    end
  end

  // stage 6: front vector, rounded half away from zero
  logic [2*F-1:0]            px, pz;
  logic [F-1:0]              mx, mz;
  logic signed [W-1:0]       fx, fy, fz;
  logic signed [FRONT_W-1:0] s6_fx, s6_fy, s6_fz;
  logic [YAW_W-1:0]          s6_yaw;
  logic signed [PITCH_W-1:0] s6_pitch;
  logic [FOV_W-1:0]          s6_fov;

  always_comb begin
    px = (2*F)'(s5_cy) * (2*F)'(s5_cp);
    pz = (2*F)'(s5_sy) * (2*F)'(s5_cp);
    mx = F'((px + ((2*F)'(1) << (F - 1))) >> F);
    mz = F'((pz + ((2*F)'(1) << (F - 1))) >> F);
    fx = s5_cy_neg ? -W'(mx) : W'(mx);
    fz = s5_sy_neg ? -W'(mz) : W'(mz);
    fy = s5_sp_neg ? -W'(s5_sp) : W'(s5_sp);
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      s6_fx    <= fx[FRONT_W-1:0];
      s6_fy    <= fy[FRONT_W-1:0];
      s6_fz    <= fz[FRONT_W-1:0];
      s6_yaw   <= s5_yaw;
      s6_pitch <= s5_pitch;
      s6_fov   <= s5_fov;
    end
  end

  assign res.valid       = v6;
  assign res.front_x     = s6_fx;
  assign res.front_y     = s6_fy;
  assign res.front_z     = s6_fz;
  assign res.yaw_angle   = s6_yaw;
  assign res.pitch_angle = s6_pitch;
  assign res.fov_angle   = s6_fov;

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> v1)
    else $error("accepted item missing from first stage");

  a_state_range: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (yaw < YAW_W'(YAW_FULL) && pitch <= PITCH_W'(PITCH_LIMIT) &&
            pitch >= -PITCH_W'(PITCH_LIMIT) && fov >= FOV_W'(FOV_MIN) &&
            fov <= FOV_W'(FOV_MAX)))
    else $error("orientation state out of range");

  a_first_move: assert property (@(posedge clk) disable iff (rst)
    $fell(first_pend) |-> $past(req.valid && req.ready && req.req_type == REQ_MOVE))
    else $error("first move cleared without a move transfer");

  a_load_once: assert property (@(posedge clk) disable iff (rst)
    $rose(loaded) |-> (v4 && $past(v3)))
    else $error("start settings loaded without an item");

endmodule
